/* hdl/quadratic_shading_correction_core_assert.svh */
// assertion macros used by the shading correction raster module
// the module using them must have clk and rst_n in scope
`ifndef QUADRATIC_SHADING_CORRECTION_CORE_ASSERT_SVH
`define QUADRATIC_SHADING_CORRECTION_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define QSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define QSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/qsc_pkg.sv */
package qsc_pkg;

  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 11;
  localparam int COEF_W      = 40;
  localparam int COEF_LO_W   = 20;
  localparam int FRAC_BITS   = 24;
  localparam int MID_GREY    = 128;
  localparam int CFG_IDX_W   = 4;
  localparam int MAX_DIM_DEF = 1024;
  localparam int SIZE_RESET  = 1024;
  localparam int NUM_TERMS   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST   = 4'd7;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [COEF_W-1:0] coef_xx;
    logic [COEF_W-1:0] coef_yy;
    logic [COEF_W-1:0] coef_xy;
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [COEF_W-1:0] coef_const;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } tag_t;

endpackage

/* hdl/qsc_cfg.sv */
module qsc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qsc_pkg::COEF_W-1:0]       cfg_data,
  output qsc_pkg::cfg_t                    cfg
);
  import qsc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= SIZE_W'(SIZE_RESET);
      cfg_r.frame_height <= SIZE_W'(SIZE_RESET);
      cfg_r.coef_xx      <= '0;
      cfg_r.coef_yy      <= '0;
      cfg_r.coef_xy      <= '0;
      cfg_r.coef_x       <= '0;
      cfg_r.coef_y       <= '0;
      cfg_r.coef_const   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[SIZE_W-1:0];
        REG_COEF_XX:      cfg_r.coef_xx      <= cfg_data;
        REG_COEF_YY:      cfg_r.coef_yy      <= cfg_data;
        REG_COEF_XY:      cfg_r.coef_xy      <= cfg_data;
        REG_COEF_X:       cfg_r.coef_x       <= cfg_data;
        REG_COEF_Y:       cfg_r.coef_y       <= cfg_data;
        REG_COEF_CONST:   cfg_r.coef_const   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/qsc_raster.sv */
module qsc_raster #(
  parameter int MAX_DIM = qsc_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qsc_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [qsc_pkg::PIX_W-1:0]    in_pixel_in,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [$clog2(MAX_DIM)-1:0]   x_out,
  output logic [$clog2(MAX_DIM)-1:0]   y_out,
  output qsc_pkg::tag_t                tag_out
);
  import qsc_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = ((CW + 1 > SIZE_W) ? CW + 1 : SIZE_W) + 1;

  logic [CW-1:0] col_r, row_r;
  logic [CW-1:0] x_r, y_r;
  tag_t          tag_r;
  logic          v_r;
  logic [EW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic          last_col, last_row, ready, acc;

  // zero acts as one, oversize clamps to the largest frame
  always_comb begin
    w_raw = EW'(cfg.frame_width);
    h_raw = EW'(cfg.frame_height);
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = EW'(1);
    end else if (h_raw > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = h_raw;
    end
  end

  assign last_col = (EW'(col_r) + EW'(1)) >= w_eff;
  assign last_row = (EW'(row_r) + EW'(1)) >= h_eff;
  assign ready    = !v_r || dn_ready;
  assign in_stall = !ready;
  assign acc      = in_valid && ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v_r   <= 1'b0;
    end else begin
      if (ready) begin
        v_r <= in_valid;
      end
      if (acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r             <= col_r;
      y_r             <= row_r;
      tag_r.pixel     <= in_pixel_in;
      tag_r.frame_end <= last_col && last_row;
    end
  end

  assign dn_valid = v_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign tag_out  = tag_r;

`include "quadratic_shading_correction_core_assert.svh"

  `QSC_ASSERT_SAME(a_col_in_range, 1'b1, EW'(col_r) < EW'(MAX_DIM), "column out of range")
  `QSC_ASSERT_NEXT(a_col_wrap, acc && last_col, col_r == '0, "column did not wrap")
  `QSC_ASSERT_NEXT(a_col_step, acc && !last_col, col_r == $past(col_r) + CW'(1), "column skipped")
  `QSC_ASSERT_NEXT(a_frame_wrap, acc && last_col && last_row, row_r == '0, "row did not wrap")

endmodule

/* hdl/qsc_surface.sv */
module qsc_surface #(
  parameter int MAX_DIM = qsc_pkg::MAX_DIM_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  qsc_pkg::cfg_t                                        cfg,
  input  logic                                                 up_valid,
  output logic                                                 up_ready,
  input  logic [$clog2(MAX_DIM)-1:0]                           x_in,
  input  logic [$clog2(MAX_DIM)-1:0]                           y_in,
  input  qsc_pkg::tag_t                                        tag_in,
  output logic                                                 dn_valid,
  input  logic                                                 dn_ready,
  output logic signed [qsc_pkg::COEF_W+2*$clog2(MAX_DIM)+3:0]  sum_out,
  output qsc_pkg::tag_t                                        tag_out
);
  import qsc_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int TW   = 2 * CW;
  localparam int HI_W = COEF_W - COEF_LO_W;
  localparam int LP_W = COEF_LO_W + TW;
  localparam int HP_W = HI_W + TW + 1;
  localparam int PW   = COEF_W + TW + 1;
  localparam int SW   = PW + 3;
  localparam int NS   = 6;

  logic [NS-1:0]                  v_r;
  logic [NS-1:0]                  rdy;
  tag_t                           tag_r [NS];
  logic [COEF_W-1:0]              coef [NUM_TERMS];
  // term order: x*x, y*y, x*y, x, y
  logic [TW-1:0]                  term_r [NUM_TERMS];
  logic [LP_W-1:0]                lo_r [NUM_TERMS];
  logic signed [HP_W-1:0]         hi_r [NUM_TERMS];
  logic signed [PW-1:0]           prod_r [NUM_TERMS];
  logic signed [COEF_W-1:0]       const_r1, const_r2, const_r3;
  logic signed [SW-1:0]           pa_r, pb_r, pc_r, pab_r, pc2_r, sum_r;

  assign coef[0] = cfg.coef_xx;
  assign coef[1] = cfg.coef_yy;
  assign coef[2] = cfg.coef_xy;
  assign coef[3] = cfg.coef_x;
  assign coef[4] = cfg.coef_y;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign sum_out  = sum_r;
  assign tag_out  = tag_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tag_r[0]  <= tag_in;
      term_r[0] <= TW'(x_in) * TW'(x_in);
      term_r[1] <= TW'(y_in) * TW'(y_in);
      term_r[2] <= TW'(x_in) * TW'(y_in);
      term_r[3] <= TW'(x_in);
      term_r[4] <= TW'(y_in);
    end
    // coefficient split into unsigned low and signed high halves
    if (rdy[1]) begin
      tag_r[1] <= tag_r[0];
      const_r1 <= $signed(cfg.coef_const);
      for (int i = 0; i < NUM_TERMS; i++) begin
        lo_r[i] <= LP_W'(coef[i][COEF_LO_W-1:0]) * LP_W'(term_r[i]);
        hi_r[i] <= HP_W'($signed(coef[i][COEF_W-1:COEF_LO_W]))
                   * HP_W'($signed({1'b0, term_r[i]}));
      end
    end
    if (rdy[2]) begin
      tag_r[2] <= tag_r[1];
      const_r2 <= const_r1;
      for (int i = 0; i < NUM_TERMS; i++) begin
        prod_r[i] <= $signed({hi_r[i], {COEF_LO_W{1'b0}}} + PW'(lo_r[i]));
      end
    end
    if (rdy[3]) begin
      tag_r[3] <= tag_r[2];
      const_r3 <= const_r2;
      pa_r     <= SW'(prod_r[0]) + SW'(prod_r[1]);
      pb_r     <= SW'(prod_r[2]) + SW'(prod_r[3]);
      pc_r     <= SW'(prod_r[4]);
    end
    if (rdy[4]) begin
      tag_r[4] <= tag_r[3];
      pab_r    <= pa_r + pb_r;
      pc2_r    <= pc_r + SW'(const_r3);
    end
    if (rdy[5]) begin
      tag_r[5] <= tag_r[4];
      sum_r    <= pab_r + pc2_r;
    end
  end

endmodule

/* hdl/qsc_correct.sv */
module qsc_correct #(
  parameter int MAX_DIM = qsc_pkg::MAX_DIM_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 up_valid,
  output logic                                                 up_ready,
  input  logic signed [qsc_pkg::COEF_W+2*$clog2(MAX_DIM)+3:0]  sum_in,
  input  qsc_pkg::tag_t                                        tag_in,
  output logic                                                 out_valid,
  input  logic                                                 out_stall,
  output logic [qsc_pkg::PIX_W-1:0]                            out_pixel_out,
  output logic                                                 out_frame_end
);
  import qsc_pkg::*;

  localparam int SW = COEF_W + 2 * $clog2(MAX_DIM) + 4;
  localparam int VW = SW + 1;

  logic [PIX_W:0]    base;
  logic [VW-1:0]     diff;
  logic [PIX_W-1:0]  pix_nxt;
  logic              out_valid_r;
  logic [PIX_W-1:0]  pixel_r;
  logic              frame_end_r;

  // (pixel + mid grey) in fixed point minus surface, then clamp
  always_comb begin
    base = {1'b0, tag_in.pixel} + (PIX_W + 1)'(MID_GREY);
    diff = (VW'(base) << FRAC_BITS) - VW'(sum_in);
    if (diff[VW-1]) begin
      pix_nxt = '0;
    end else if (diff >= (VW'(1) << (PIX_W + FRAC_BITS))) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = diff[FRAC_BITS +: PIX_W];
    end
  end

  assign up_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pixel_r     <= pix_nxt;
      frame_end_r <= tag_in.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pixel_r;
  assign out_frame_end = frame_end_r;

endmodule

/* hdl/quadratic_shading_correction_core.sv */
// an accepted word passes the raster, multiply and add, and correction registers
// throughput: one word per cycle while out_stall is low
// a stalled output lets the stages behind it fill before the input stalls
// reset (synchronous, rst_n low): pipeline emptied, column and row at 0,
// frame sizes 1024, all coefficients 0
module quadratic_shading_correction_core #(
  parameter int MAX_DIM = qsc_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [qsc_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [qsc_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qsc_pkg::COEF_W-1:0]     cfg_data
);
  import qsc_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = COEF_W + 2 * CW + 4;

  cfg_t                  cfg;
  logic                  r_valid, r_ready, s_valid, s_ready;
  logic [CW-1:0]         x, y;
  tag_t                  r_tag, s_tag;
  logic signed [SW-1:0]  sum;

  qsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qsc_raster #(.MAX_DIM(MAX_DIM)) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .dn_valid    (r_valid),
    .dn_ready    (r_ready),
    .x_out       (x),
    .y_out       (y),
    .tag_out     (r_tag)
  );

  qsc_surface #(.MAX_DIM(MAX_DIM)) u_surface (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (r_valid),
    .up_ready (r_ready),
    .x_in     (x),
    .y_in     (y),
    .tag_in   (r_tag),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .sum_out  (sum),
    .tag_out  (s_tag)
  );

  qsc_correct #(.MAX_DIM(MAX_DIM)) u_correct (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (s_valid),
    .up_ready      (s_ready),
    .sum_in        (sum),
    .tag_in        (s_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

/* tb/sv/quadratic_shading_correction_core_tb.sv */
module quadratic_shading_correction_core_tb;
  import qsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_PIXELS  = 1500;
  localparam int TAIL_PIXELS    = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_frame_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  cfg_t        shade_cfg;
  int unsigned pos_col;
  int unsigned pos_row;
  tag_t        corrected_q[$];

  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned hold_len = 0;
  int unsigned errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_words = 0;
  int unsigned n_frames = 0;
  int unsigned n_clip_lo = 0;
  int unsigned n_clip_hi = 0;
  int unsigned n_writes = 0;
  int unsigned n_in_stalls = 0;
  int unsigned quiet_cycles = 0;

  quadratic_shading_correction_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [127:0] widen(input logic [COEF_W-1:0] c);
    return $signed({{(128-COEF_W){c[COEF_W-1]}}, c});
  endfunction

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(s);
  endfunction

  // surface at the current position, then step the raster position
  function automatic tag_t correct_pixel(input logic [PIX_W-1:0] pix);
    logic signed [127:0] xs;
    logic signed [127:0] ys;
    logic signed [127:0] surf;
    logic signed [127:0] level;
    int unsigned w;
    int unsigned h;
    bit last_col;
    bit last_row;
    tag_t r;
    w = clamp_size(shade_cfg.frame_width);
    h = clamp_size(shade_cfg.frame_height);
    xs = 128'(pos_col);
    ys = 128'(pos_row);
    surf = widen(shade_cfg.coef_xx) * xs * xs + widen(shade_cfg.coef_yy) * ys * ys
         + widen(shade_cfg.coef_xy) * xs * ys + widen(shade_cfg.coef_x) * xs
         + widen(shade_cfg.coef_y) * ys + widen(shade_cfg.coef_const);
    level = $signed({120'd0, pix}) + 128'sd128;
    level = (level <<< FRAC_BITS) - surf;
    if (level < 0) begin
      r.pixel = '0;
      n_clip_lo++;
    end else if (level >= (128'sd256 <<< FRAC_BITS)) begin
      r.pixel = '1;
      n_clip_hi++;
    end else begin
      r.pixel = level[FRAC_BITS +: PIX_W];
    end
    last_col = pos_col + 1 >= w;
    last_row = pos_row + 1 >= h;
    r.frame_end = last_col && last_row;
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 7) == 0) return r[COEF_W-1:0];
    r = r >> (64 - $urandom_range(10, 32));
    if ($urandom_range(0, 1) == 1) r = -r;
    return r[COEF_W-1:0];
  endfunction

  // upper bits are random and must be ignored
  function automatic logic [COEF_W-1:0] rand_size_word();
    logic [COEF_W-1:0] w;
    w = COEF_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 11))
      0: w[SIZE_W-1:0] = '0;
      1: w[SIZE_W-1:0] = SIZE_W'(MAX_DIM_DEF);
      2: w[SIZE_W-1:0] = SIZE_W'($urandom_range(MAX_DIM_DEF + 1, 2047));
      3: w[SIZE_W-1:0] = 1;
      default: w[SIZE_W-1:0] = SIZE_W'($urandom_range(2, 20));
    endcase
    return w;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      corrected_q = {corrected_q, correct_pixel(in_pixel_in)};
      n_pixels++;
    end
    if (rst_n && in_valid && in_stall) n_in_stalls++;
  end

  always @(posedge clk) begin
    tag_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_words++;
      if (corrected_q.size() == 0) begin
        flag_error($sformatf("unexpected word pixel_out=%0d frame_end=%0b",
                             out_pixel_out, out_frame_end));
      end else begin
        want = corrected_q.pop_front();
        if (want.frame_end) n_frames++;
        if (out_pixel_out !== want.pixel)
          flag_error($sformatf("word %0d pixel_out expected %0d got %0d",
                               n_words, want.pixel, out_pixel_out));
        if (out_frame_end !== want.frame_end)
          flag_error($sformatf("word %0d frame_end expected %0b got %0b",
                               n_words, want.frame_end, out_frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d cycles without a handshake", quiet_cycles);
        $display("quadratic_shading_correction_core_tb NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, or one long hold-off when asked
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        n = hold_len;
        hold_len = 0;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
    case (idx)
      REG_FRAME_WIDTH:  shade_cfg.frame_width  = data[SIZE_W-1:0];
      REG_FRAME_HEIGHT: shade_cfg.frame_height = data[SIZE_W-1:0];
      REG_COEF_XX:      shade_cfg.coef_xx      = data;
      REG_COEF_YY:      shade_cfg.coef_yy      = data;
      REG_COEF_XY:      shade_cfg.coef_xy      = data;
      REG_COEF_X:       shade_cfg.coef_x       = data;
      REG_COEF_Y:       shade_cfg.coef_y       = data;
      REG_COEF_CONST:   shade_cfg.coef_const   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic randomise_setup();
    if ($urandom_range(0, 2) != 0) write_reg(REG_FRAME_WIDTH, rand_size_word());
    if ($urandom_range(0, 2) != 0) write_reg(REG_FRAME_HEIGHT, rand_size_word());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_XX, rand_coef());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_YY, rand_coef());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_XY, rand_coef());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_X, rand_coef());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_Y, rand_coef());
    if ($urandom_range(0, 2) != 0) write_reg(REG_COEF_CONST, rand_coef());
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(8, 15)), COEF_W'({$urandom(), $urandom()}));
  endtask

  // zero surface straight out of reset
  task automatic test_reset_state();
    send_pixel(8'd0);
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain();
  endtask

  // one-pixel frames, fractions just below zero and either side of 256
  task automatic test_clip_edges();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    write_reg(REG_COEF_CONST, 40'h00_8000_0001);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();
    write_reg(REG_COEF_CONST, 40'hFF_8000_0001);
    send_pixel(8'd0);
    send_pixel(8'd1);
    drain();
  endtask

  task automatic test_coef_extremes();
    write_reg(REG_FRAME_WIDTH, 40'd3);
    write_reg(REG_FRAME_HEIGHT, 40'd2);
    write_reg(REG_COEF_XX, 40'h7F_FFFF_FFFF);
    write_reg(REG_COEF_YY, 40'h80_0000_0000);
    write_reg(REG_COEF_XY, 40'h7F_FFFF_FFFF);
    write_reg(REG_COEF_X, 40'h80_0000_0000);
    write_reg(REG_COEF_Y, 40'h7F_FFFF_FFFF);
    write_reg(REG_COEF_CONST, '0);
    repeat (3) begin
      send_pixel(8'd0);
      send_pixel(8'd255);
    end
    drain();
  endtask

  // shrink the frame under the counters, stray indexes, oversize frame
  task automatic test_frame_geometry();
    write_reg(REG_FRAME_WIDTH, 40'd4);
    write_reg(REG_FRAME_HEIGHT, 40'd4);
    write_reg(REG_COEF_XX, '0);
    write_reg(REG_COEF_YY, '0);
    write_reg(REG_COEF_XY, '0);
    write_reg(REG_COEF_X, 40'h00_0100_0000);
    write_reg(REG_COEF_Y, 40'hFF_F000_0000);
    repeat (6) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_WIDTH, 40'd2);
    write_reg(REG_FRAME_HEIGHT, 40'd1);
    write_reg(CFG_IDX_W'(8), 40'hFF_FFFF_FFFF);
    write_reg(CFG_IDX_W'(15), 40'hAA_5555_AAAA);
    repeat (3) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_WIDTH, 40'd2047);
    write_reg(REG_FRAME_HEIGHT, 40'd2047);
    repeat (2) send_pixel(rand_pixel());
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned n;
    target = n_pixels + RANDOM_PIXELS;
    while (n_pixels < target) begin
      randomise_setup();
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      n = $urandom_range(40, 140);
      repeat (n) send_pixel(rand_pixel());
      drain();
    end
  endtask

  // long receiver hold-off while pixels keep coming
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    randomise_setup();
    hold_len = HOLD_CYCLES;
    repeat (60) send_pixel(rand_pixel());
    drain();
  endtask

  task automatic test_quiet_tail();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    randomise_setup();
    repeat (TAIL_PIXELS) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    shade_cfg   = '0;
    shade_cfg.frame_width  = SIZE_W'(SIZE_RESET);
    shade_cfg.frame_height = SIZE_W'(SIZE_RESET);
    pos_col = 0;
    pos_row = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_clip_edges();
    test_coef_extremes();
    test_frame_geometry();
    test_random_frames();
    test_backpressure();
    test_quiet_tail();

    if (corrected_q.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", corrected_q.size()));
    $display("run: %0d pixels in, %0d words checked, %0d frame ends, %0d register writes",
             n_pixels, n_words, n_frames, n_writes);
    $display("run: %0d clipped low, %0d clipped high, %0d input stall cycles, %0d mismatches",
             n_clip_lo, n_clip_hi, n_in_stalls, errors);
    if (errors == 0) begin
      $display("quadratic_shading_correction_core_tb OK");
    end else begin
      $display("quadratic_shading_correction_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/qsc_pkg.sv
hdl/qsc_cfg.sv
hdl/qsc_raster.sv
hdl/qsc_surface.sv
hdl/qsc_correct.sv
hdl/quadratic_shading_correction_core.sv
tb/sv/quadratic_shading_correction_core_tb.sv
